### sv/ndss_pkg.sv
package ndss_pkg;

  localparam int CMD_W     = 2;
  localparam int DIGIT_W   = 4;
  localparam int PIN_W     = 8;
  localparam int HALF_W    = 32;
  localparam int PAT_W     = 2 * HALF_W;
  localparam int FIELD_W   = 10;
  localparam int NUM_TUBES = 6;
  localparam int LANES     = 4;
  localparam int NUM_SHIFTS = PAT_W / LANES;
  localparam int STEP_W    = $clog2(NUM_SHIFTS + 1);
  localparam int PIN_IDX_W = $clog2(PAT_W);

  localparam logic [CMD_W-1:0] CMD_DIGITS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RAW    = 2'd2;

  localparam logic ACT_SHIFT = 1'b0;
  localparam logic ACT_LATCH = 1'b1;

  localparam logic [STEP_W-1:0] LATCH_STEP = STEP_W'(NUM_SHIFTS);

  localparam logic [PIN_W-1:0] PIN_FIRST = 8'd1;
  localparam logic [PIN_W-1:0] PIN_LAST  = PIN_W'(PAT_W);

  localparam logic [FIELD_W-1:0] ZERO_FIELD = 10'h200;
  localparam logic [FIELD_W-1:0] FIELD_MASK = 10'h3FF;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [PAT_W-1:0]   pattern_t;

  typedef struct packed {
    logic     cmd_ok;
    pattern_t pattern;
  } pat_res_t;

  function automatic logic [FIELD_W-1:0] digit_field(input digit_t d);
    logic [FIELD_W-1:0] f;
    f = '0;
    if (d == '0) begin
      f = ZERO_FIELD;
    end else if (d <= 4'd10) begin
      f = FIELD_MASK & (FIELD_W'(1) << (d - 4'd1));
    end
    return f;
  endfunction

endpackage

### sv/ndss_intf.sv
interface ndss_in_if;
  import ndss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [DIGIT_W-1:0]   digit_0;
  logic [DIGIT_W-1:0]   digit_1;
  logic [DIGIT_W-1:0]   digit_2;
  logic [DIGIT_W-1:0]   digit_3;
  logic [DIGIT_W-1:0]   digit_4;
  logic [DIGIT_W-1:0]   digit_5;
  logic [PIN_W-1:0]     pin_number;
  logic [HALF_W-1:0]    pattern_high;
  logic [HALF_W-1:0]    pattern_low;

  modport source (
    output valid, command, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
           pin_number, pattern_high, pattern_low,
    input  ready
  );

  modport sink (
    input  valid, command, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
           pin_number, pattern_high, pattern_low,
    output ready
  );
endinterface

interface ndss_out_if;
  logic valid;
  logic ready;
  logic action;
  logic lane_one;
  logic lane_two;
  logic lane_three;
  logic lane_four;
  logic final_step;

  modport source (
    output valid, action, lane_one, lane_two, lane_three, lane_four, final_step,
    input  ready
  );

  modport sink (
    input  valid, action, lane_one, lane_two, lane_three, lane_four, final_step,
    output ready
  );
endinterface

### sv/ndss_pattern.sv
module ndss_pattern (
  input  logic [ndss_pkg::CMD_W-1:0]  command,
  input  ndss_pkg::digit_t            digits [ndss_pkg::NUM_TUBES],
  input  logic [ndss_pkg::PIN_W-1:0]  pin_number,
  input  logic [ndss_pkg::HALF_W-1:0] pattern_high,
  input  logic [ndss_pkg::HALF_W-1:0] pattern_low,
  output ndss_pkg::pat_res_t          res
);
  import ndss_pkg::*;

  logic [PIN_W-1:0] pin_m1;
  pattern_t         digit_pat;

  assign pin_m1 = pin_number - PIN_FIRST;

  always_comb begin
    digit_pat = '0;
    for (int i = 0; i < NUM_TUBES; i++) begin
      digit_pat[i*FIELD_W +: FIELD_W] = digit_field(digits[i]);
    end
  end

  always_comb begin
    res.cmd_ok  = 1'b0;
    res.pattern = '0;
    unique case (command)
      CMD_DIGITS: begin
        res.cmd_ok  = 1'b1;
        res.pattern = digit_pat;
      end
      CMD_PIN: begin
        res.cmd_ok  = (pin_number >= PIN_FIRST) && (pin_number <= PIN_LAST);
        res.pattern = PAT_W'(1) << pin_m1[PIN_IDX_W-1:0];
      end
      CMD_RAW: begin
        res.cmd_ok  = 1'b1;
        res.pattern = {pattern_high, pattern_low};
      end
      default: begin
        res.cmd_ok  = 1'b0;
        res.pattern = '0;
      end
    endcase
  end

endmodule

### sv/ndss_serializer.sv
module ndss_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_valid,
  input  ndss_pkg::pattern_t load_pattern,
  output logic               load_ready,
  ndss_out_if.source         out_ch
);
  import ndss_pkg::*;

  logic              busy_r, busy_nxt;
  pattern_t          pat_r, pat_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last_step;
  logic              out_xfer;

  assign last_step  = (step_r == LATCH_STEP);
  assign out_xfer   = busy_r && out_ch.ready;
  assign load_ready = !busy_r || (out_xfer && last_step);

  always_comb begin
    busy_nxt = busy_r;
    pat_nxt  = pat_r;
    step_nxt = step_r;
    if (out_xfer) begin
      pat_nxt  = pat_r << LANES;
      step_nxt = step_r + STEP_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
    if (load_valid && load_ready) begin
      busy_nxt = 1'b1;
      pat_nxt  = load_pattern;
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    pat_r <= pat_nxt;
  end

  // pattern drains to zero after sixteen shifts, so lanes read zero on the latch
  assign out_ch.valid      = busy_r;
  assign out_ch.action     = last_step ? ACT_LATCH : ACT_SHIFT;
  assign out_ch.final_step = last_step;
  assign out_ch.lane_four  = pat_r[PAT_W-1];
  assign out_ch.lane_three = pat_r[PAT_W-2];
  assign out_ch.lane_two   = pat_r[PAT_W-3];
  assign out_ch.lane_one   = pat_r[PAT_W-4];

endmodule

### sv/nixie_digit_shift_serializer.sv
// Each accepted command forms a 64-bit tube pattern and plays it out as 16 four-lane
// nibble shifts, high nibble first, followed by one latch pulse with final_step set:
// 17 result transfers per command, one per cycle while out_ch.ready is high. Commands
// with an unused code or a pin number outside 1 to 64 are dropped with no result. The
// command register is freed as soon as its pattern moves into the shift register, so
// the next command waits there and starts playing out in the cycle after the latch
// pulse; sustained throughput is set by the single output shift register. A command
// goes through the command register, then the shift register, before its first shift.
module nixie_digit_shift_serializer (
  input  logic      clk,
  input  logic      rst_n,
  ndss_in_if.sink   in_ch,
  ndss_out_if.source out_ch
);
  import ndss_pkg::*;

  logic               cmd_vld_r;
  logic [CMD_W-1:0]   cmd_r;
  digit_t             digit_r [NUM_TUBES];
  logic [PIN_W-1:0]   pin_r;
  logic [HALF_W-1:0]  pat_hi_r;
  logic [HALF_W-1:0]  pat_lo_r;

  pat_res_t           pat_res;
  logic               ser_ready;
  logic               cmd_done;
  logic               in_xfer;

  assign cmd_done    = cmd_vld_r && (ser_ready || !pat_res.cmd_ok);
  assign in_ch.ready = !cmd_vld_r || cmd_done;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else if (in_xfer) begin
      cmd_vld_r <= 1'b1;
    end else if (cmd_done) begin
      cmd_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r      <= in_ch.command;
      digit_r[0] <= in_ch.digit_0;
      digit_r[1] <= in_ch.digit_1;
      digit_r[2] <= in_ch.digit_2;
      digit_r[3] <= in_ch.digit_3;
      digit_r[4] <= in_ch.digit_4;
      digit_r[5] <= in_ch.digit_5;
      pin_r      <= in_ch.pin_number;
      pat_hi_r   <= in_ch.pattern_high;
      pat_lo_r   <= in_ch.pattern_low;
    end
  end

  ndss_pattern u_pattern (
    .command      (cmd_r),
    .digits       (digit_r),
    .pin_number   (pin_r),
    .pattern_high (pat_hi_r),
    .pattern_low  (pat_lo_r),
    .res          (pat_res)
  );

  ndss_serializer u_serializer (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (cmd_vld_r && pat_res.cmd_ok),
    .load_pattern (pat_res.pattern),
    .load_ready   (ser_ready),
    .out_ch       (out_ch)
  );

endmodule
